FILE: hdl/psns_pkg.sv
package psns_pkg;

	localparam int MAX_POINTS = 4096;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int INDEX_W    = 12;
	localparam int SKIP_W     = 13;
	localparam int CUR_W      = ((CNT_W > SKIP_W) ? CNT_W : SKIP_W) + 1;

	localparam logic [2:0] CMD_INSERT  = 3'd0;
	localparam logic [2:0] CMD_CLOSEST = 3'd1;
	localparam logic [2:0] CMD_EXISTS  = 3'd2;
	localparam logic [2:0] CMD_NEXT    = 3'd3;
	localparam logic [2:0] CMD_STRIDED = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic signed [31:0] lat;
		logic signed [31:0] lon;
		logic signed [31:0] elev;
	} point_t;

endpackage

FILE: hdl/point_store_nearest_search.sv
// Point store with nearest-point search.
// Input channel (in_valid/in_ready) takes one command word: insert, closest,
// exists within radius, next, or strided next. Output channel
// (out_valid/out_ready) returns exactly one result word per command.
// Points live in a 4096 x 96-bit on-chip array with one registered read port;
// it is not cleared at reset, only entries below the fill count are read.
// Insert, unknown commands, a search of an empty store and a next or strided
// next with nothing to return go straight to the done state; a next or strided
// next that returns a point passes through the fetch and load states first.
// Closest walks each stored point through the address, difference, latitude
// square, longitude square, sum and compare states; exists first squares the
// radius and stops at the first hit. The single shared 32x32 squarer is used
// once for latitude and once for longitude per point. One command is in work
// at a time; in_ready is high only while idle.
// The result sits in an output register, so the block goes back to idle and
// takes the next command while an earlier result waits for out_ready; a
// finished result waits for the output register to free up.
// Reset (arst_n low) empties the store, clears the read cursor and drops any
// pending result.
module point_store_nearest_search (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [2:0]                           cmd,
	input  logic signed [31:0]                   lat,
	input  logic signed [31:0]                   lon,
	input  logic signed [31:0]                   elev,
	input  logic [30:0]                          radius,
	input  logic [11:0]                          start_req,
	input  logic [psns_pkg::SKIP_W-1:0]          skip,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           status,
	output logic [psns_pkg::INDEX_W-1:0]         index,
	output logic signed [31:0]                   out_lat,
	output logic signed [31:0]                   out_lon,
	output logic signed [31:0]                   out_elev,
	output logic [63:0]                          dist_sq
);
	import psns_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_RSQ   = 12'b0000_0000_0010,
		S_RLAT  = 12'b0000_0000_0100,
		S_ADDR  = 12'b0000_0000_1000,
		S_DIFF  = 12'b0000_0001_0000,
		S_SQA   = 12'b0000_0010_0000,
		S_SQB   = 12'b0000_0100_0000,
		S_SUM   = 12'b0000_1000_0000,
		S_CMP   = 12'b0001_0000_0000,
		S_FETCH = 12'b0010_0000_0000,
		S_LOAD  = 12'b0100_0000_0000,
		S_DONE  = 12'b1000_0000_0000
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [CUR_W-1:0]     cursor_q;
	logic                 ovalid_q;

	point_t               mem [MAX_POINTS];
	point_t               rd_q;
	point_t               cand_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [2:0]           cmd_q;
	logic signed [31:0]   qlat_q;
	logic signed [31:0]   qlon_q;
	logic [30:0]          rad_q;
	logic [61:0]          r2_q;
	logic [31:0]          dlat_q;
	logic [31:0]          dlon_q;
	logic [63:0]          mprod_q;
	logic [63:0]          sqa_q;
	logic [63:0]          d_q;

	logic [1:0]           res_status_q;
	logic [INDEX_W-1:0]   res_index_q;
	point_t               res_pt_q;
	logic [63:0]          res_dist_q;

	logic [1:0]           ostatus_q;
	logic [INDEX_W-1:0]   oindex_q;
	point_t               opt_q;
	logic [63:0]          odist_q;

	logic                 acc;
	logic                 wr_en;
	logic                 ofree;
	logic                 last;
	logic                 hit;
	logic                 better;
	logic                 cur_lt_cnt;
	logic                 str_pre;
	logic                 start_ok;
	logic                 fetch_go;
	logic [ADDR_W-1:0]    fetch_idx;
	logic [SKIP_W-1:0]    sk;
	logic [31:0]          sq_op;
	logic [32:0]          diff_lat;
	logic [32:0]          diff_lon;
	logic [32:0]          neg_lat;
	logic [32:0]          neg_lon;
	logic [64:0]          sum;
	logic [63:0]          dsum;
	logic                 scanning;

	assign in_ready   = (state_q == S_IDLE);
	assign acc        = in_valid && in_ready;
	assign wr_en      = acc && (cmd == CMD_INSERT) && (count_q < CNT_W'(MAX_POINTS));
	assign ofree      = !ovalid_q || out_ready;
	assign last       = ((CNT_W'(addr_q) + CNT_W'(1)) == count_q);
	assign hit        = (d_q < {2'b00, r2_q});
	assign better     = (addr_q == '0) || (d_q < res_dist_q);
	assign cur_lt_cnt = (cursor_q < CUR_W'(count_q));
	assign str_pre    = (cursor_q < CUR_W'(start_req));
	assign start_ok   = (CUR_W'(start_req) < CUR_W'(count_q));
	assign sk         = (skip == '0) ? SKIP_W'(1) : skip;

	assign fetch_go  = ((cmd == CMD_NEXT) && cur_lt_cnt) ||
		((cmd == CMD_STRIDED) && (str_pre ? start_ok : cur_lt_cnt));
	assign fetch_idx = ((cmd == CMD_STRIDED) && str_pre) ? ADDR_W'(start_req) :
		cursor_q[ADDR_W-1:0];

	assign diff_lat = {qlat_q[31], qlat_q} - {rd_q.lat[31], rd_q.lat};
	assign diff_lon = {qlon_q[31], qlon_q} - {rd_q.lon[31], rd_q.lon};
	assign neg_lat  = -diff_lat;
	assign neg_lon  = -diff_lon;

	assign sum  = {1'b0, sqa_q} + {1'b0, mprod_q};
	assign dsum = sum[64] ? '1 : sum[63:0];

	always_comb begin
		case (state_q)
			S_RSQ:   sq_op = {1'b0, rad_q};
			S_SQB:   sq_op = dlon_q;
			default: sq_op = dlat_q;
		endcase
	end

	// point array, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[ADDR_W-1:0]] <= '{lat: lat, lon: lon, elev: elev};
		end
		rd_q <= mem[addr_q];
	end

	// shared squarer
	always_ff @(posedge clk) begin
		mprod_q <= sq_op * sq_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			cursor_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && ofree) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (cmd)
							CMD_INSERT: begin
								state_q <= S_DONE;
								if (wr_en) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_CLOSEST: begin
								cursor_q <= '0;
								state_q  <= (count_q != '0) ? S_ADDR : S_DONE;
							end
							CMD_EXISTS: begin
								state_q <= (count_q != '0) ? S_RSQ : S_DONE;
							end
							CMD_NEXT: begin
								if (cur_lt_cnt) begin
									cursor_q <= cursor_q + CUR_W'(1);
									state_q  <= S_FETCH;
								end else begin
									state_q <= S_DONE;
								end
							end
							CMD_STRIDED: begin
								if (str_pre && start_ok) begin
									cursor_q <= CUR_W'(start_req) + CUR_W'(sk);
									state_q  <= S_FETCH;
								end else if (!str_pre && cur_lt_cnt) begin
									cursor_q <= cursor_q + CUR_W'(sk);
									state_q  <= S_FETCH;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_RSQ:   state_q <= S_RLAT;
				S_RLAT:  state_q <= S_ADDR;
				S_ADDR:  state_q <= S_DIFF;
				S_DIFF:  state_q <= S_SQA;
				S_SQA:   state_q <= S_SQB;
				S_SQB:   state_q <= S_SUM;
				S_SUM:   state_q <= S_CMP;
				S_CMP: begin
					if (last || ((cmd_q == CMD_EXISTS) && hit)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_ADDR;
					end
				end
				S_FETCH: state_q <= S_LOAD;
				S_LOAD:  state_q <= S_DONE;
				S_DONE: begin
					if (ofree) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_q      <= cmd;
					qlat_q     <= lat;
					qlon_q     <= lon;
					rad_q      <= radius;
					addr_q     <= fetch_go ? fetch_idx : '0;
					res_pt_q   <= '0;
					res_dist_q <= ((cmd == CMD_CLOSEST) && (count_q == '0)) ? '1 : '0;
					if (wr_en) begin
						res_status_q <= ST_OK;
						res_index_q  <= INDEX_W'(count_q);
					end else if (cmd == CMD_INSERT) begin
						res_status_q <= ST_FULL;
						res_index_q  <= '0;
					end else begin
						res_status_q <= ST_NONE;
						res_index_q  <= fetch_go ? INDEX_W'(fetch_idx) : '0;
					end
				end
			end
			S_RLAT: r2_q <= mprod_q[61:0];
			S_DIFF: begin
				cand_q <= rd_q;
				dlat_q <= diff_lat[32] ? neg_lat[31:0] : diff_lat[31:0];
				dlon_q <= diff_lon[32] ? neg_lon[31:0] : diff_lon[31:0];
			end
			S_SQB: sqa_q <= mprod_q;
			S_SUM: d_q <= dsum;
			S_CMP: begin
				if (((cmd_q == CMD_CLOSEST) && better) || ((cmd_q == CMD_EXISTS) && hit)) begin
					res_status_q <= ST_OK;
					res_index_q  <= INDEX_W'(addr_q);
					res_pt_q     <= cand_q;
					res_dist_q   <= d_q;
				end
				if (!last) begin
					addr_q <= addr_q + ADDR_W'(1);
				end
			end
			S_LOAD: begin
				res_status_q <= ST_OK;
				res_pt_q     <= rd_q;
			end
			S_DONE: begin
				if (ofree) begin
					ostatus_q <= res_status_q;
					oindex_q  <= res_index_q;
					opt_q     <= res_pt_q;
					odist_q   <= res_dist_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = ovalid_q;
	assign status    = ostatus_q;
	assign index     = oindex_q;
	assign out_lat   = opt_q.lat;
	assign out_lon   = opt_q.lon;
	assign out_elev  = opt_q.elev;
	assign dist_sq   = odist_q;

	assign scanning = (state_q == S_ADDR) || (state_q == S_DIFF) || (state_q == S_SQA) ||
		(state_q == S_SQB) || (state_q == S_SUM) || (state_q == S_CMP);

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("fill count above store depth");

	a_scan_addr: assert property (@(posedge clk) disable iff (!arst_n)
		scanning |-> (CNT_W'(addr_q) < count_q))
		else $error("scan address beyond fill count");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && (ostatus_q == ST_FULL)) |-> (count_q == CNT_W'(MAX_POINTS)))
		else $error("full status with room left");

	a_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (cmd == CMD_INSERT) && (count_q != CNT_W'(MAX_POINTS)))
		|=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not bump fill count");

	a_ok_index: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && (ostatus_q == ST_OK)) |-> (CNT_W'(oindex_q) < count_q))
		else $error("returned index not below fill count");

endmodule
